@@ design/alpn_pkg.sv @@
package alpn_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } alpn_in_t;

  typedef struct packed {
    logic [7:0]  name_byte;
    logic        in_name;
    logic        name_start;
    logic        name_end;
    logic [14:0] name_index;
    logic        done_res;
    logic [1:0]  status;
  } alpn_out_t;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusFraming = 2'd1;
  localparam logic [1:0] StatusBadName = 2'd2;

endpackage

@@ design/alpn_in_stage.sv @@
module alpn_in_stage
  import alpn_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  alpn_in_t in_data_i,
  output logic     s_valid_o,
  input  logic     s_ready_i,
  output alpn_in_t s_data_o
);

  logic     valid_q;
  alpn_in_t data_q;

  assign in_ready_o = !valid_q || s_ready_i;
  assign s_valid_o  = valid_q;
  assign s_data_o   = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= in_data_i;
    end
  end

endmodule

@@ design/alpn_parse.sv @@
module alpn_parse
  import alpn_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_valid_i,
  output logic      s_ready_o,
  input  alpn_in_t  s_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output alpn_out_t out_data_o
);

  localparam logic [1:0]  PhLenHi   = 2'd0;
  localparam logic [1:0]  PhLenLo   = 2'd1;
  localparam logic [1:0]  PhNameLen = 2'd2;
  localparam logic [1:0]  PhName    = 2'd3;
  localparam logic [16:0] SeenMax   = 17'h1FFFF;
  localparam logic [14:0] NamesMax  = 15'h7FFF;

  logic [1:0]  phase_q, phase_d;
  logic [15:0] list_len_q, list_len_d;
  logic [15:0] list_rem_q, list_rem_d;
  logic [7:0]  name_rem_q, name_rem_d;
  logic [16:0] seen_q, seen_d;
  logic [14:0] name_cnt_q, name_cnt_d;
  logic        frame_err_q, frame_err_d;
  logic        name_err_q, name_err_d;
  logic        first_q, first_d;

  logic        out_valid_q;
  alpn_out_t   out_q, res;
  logic        fire;
  logic [15:0] list_rem_dec;
  logic [7:0]  name_rem_dec;
  logic        frame_bad;

  assign s_ready_o   = !out_valid_q || out_ready_i;
  assign fire        = s_valid_i && s_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    phase_d      = phase_q;
    list_len_d   = list_len_q;
    list_rem_d   = list_rem_q;
    name_rem_d   = name_rem_q;
    name_cnt_d   = name_cnt_q;
    frame_err_d  = frame_err_q;
    name_err_d   = name_err_q;
    first_d      = first_q;
    res          = '0;
    frame_bad    = 1'b0;
    list_rem_dec = list_rem_q - 16'd1;
    name_rem_dec = name_rem_q - 8'd1;
    seen_d       = (seen_q != SeenMax) ? seen_q + 17'd1 : seen_q;

    case (phase_q)
      PhLenHi: begin
        list_len_d = {s_data_i.data_byte, 8'd0};
        phase_d    = PhLenLo;
      end
      PhLenLo: begin
        list_len_d = {list_len_q[15:8], s_data_i.data_byte};
        list_rem_d = list_len_d;
        if (list_len_d < 16'd2) begin
          frame_err_d = 1'b1;
        end
        phase_d = PhNameLen;
      end
      PhNameLen: begin
        if (!name_err_q) begin
          if (list_rem_q == 16'd0) begin
            frame_err_d = 1'b1;
          end else begin
            list_rem_d = list_rem_dec;
            if (s_data_i.data_byte == 8'd0 ||
                {8'd0, s_data_i.data_byte} > list_rem_dec) begin
              name_err_d = 1'b1;
            end else begin
              name_rem_d = s_data_i.data_byte;
              first_d    = 1'b1;
              phase_d    = PhName;
            end
          end
        end
      end
      PhName: begin
        res.name_byte  = s_data_i.data_byte;
        res.in_name    = 1'b1;
        res.name_start = first_q;
        first_d        = 1'b0;
        res.name_index = name_cnt_q;
        if (list_rem_q != 16'd0) begin
          list_rem_d = list_rem_dec;
        end
        if (name_rem_q != 8'd0) begin
          name_rem_d = name_rem_dec;
        end
        if (name_rem_d == 8'd0) begin
          res.name_end = 1'b1;
          if (name_cnt_q != NamesMax) begin
            name_cnt_d = name_cnt_q + 15'd1;
          end
          phase_d = PhNameLen;
        end
      end
      default: begin
        phase_d = PhLenHi;
      end
    endcase

    if (s_data_i.last) begin
      frame_bad = frame_err_d || (phase_d == PhLenHi) || (phase_d == PhLenLo) ||
                  (list_len_d < 16'd2) || (seen_d != ({1'b0, list_len_d} + 17'd2));
      res.done_res = 1'b1;
      res.status   = frame_bad ? StatusFraming : (name_err_d ? StatusBadName : StatusOk);
      phase_d      = PhLenHi;
      list_len_d   = '0;
      list_rem_d   = '0;
      name_rem_d   = '0;
      seen_d       = '0;
      name_cnt_d   = '0;
      frame_err_d  = 1'b0;
      name_err_d   = 1'b0;
      first_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhLenHi;
      list_len_q  <= '0;
      list_rem_q  <= '0;
      name_rem_q  <= '0;
      seen_q      <= '0;
      name_cnt_q  <= '0;
      frame_err_q <= 1'b0;
      name_err_q  <= 1'b0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        phase_q     <= phase_d;
        list_len_q  <= list_len_d;
        list_rem_q  <= list_rem_d;
        name_rem_q  <= name_rem_d;
        seen_q      <= seen_d;
        name_cnt_q  <= name_cnt_d;
        frame_err_q <= frame_err_d;
        name_err_q  <= name_err_d;
        first_q     <= first_d;
      end
      if (s_ready_o) begin
        out_valid_q <= s_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

endmodule

@@ design/alpn_protocol_list_parser.sv @@
// Path: each byte passes the input register, then the result register, before its
// result can leave. Throughput: one byte per cycle while out_ready_i is high;
// the parser state updates once per byte in one pass.
// Reset: rst_ni clears the parser to expect a list length high byte; the parser
// also returns there after every byte flagged last.
module alpn_protocol_list_parser
  import alpn_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  alpn_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output alpn_out_t out_data_o
);

  logic     s_valid;
  logic     s_ready;
  alpn_in_t s_data;

  alpn_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .s_valid_o  (s_valid),
    .s_ready_i  (s_ready),
    .s_data_o   (s_data)
  );

  alpn_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_valid),
    .s_ready_o   (s_ready),
    .s_data_i    (s_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ sim/tb.sv @@
module tb
  import alpn_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    LenHi    = 2'd0,
    LenLo    = 2'd1,
    NameLen  = 2'd2,
    NameBody = 2'd3
  } parse_phase_e;

  localparam logic [16:0] SeenMax  = 17'h1FFFF;
  localparam logic [14:0] NamesMax = 15'h7FFF;

  class alpn_parse_tracker;
    parse_phase_e phase;
    logic [15:0]  list_len;
    logic [15:0]  list_left;
    logic [7:0]   name_left;
    logic [16:0]  seen;
    logic [14:0]  names;
    logic         frame_err;
    logic         name_err;
    logic         first_byte;
    alpn_out_t    parse_results_q[$];
    int unsigned  errors;

    function void clear_body();
      phase      = LenHi;
      list_len   = '0;
      list_left  = '0;
      name_left  = '0;
      seen       = '0;
      names      = '0;
      frame_err  = 1'b0;
      name_err   = 1'b0;
      first_byte = 1'b0;
    endfunction

    function void parse_byte(alpn_in_t item);
      alpn_out_t r;
      logic      bad_frame;
      r = '0;
      if (seen != SeenMax) seen++;
      case (phase)
        LenHi: begin
          list_len = {item.data_byte, 8'h00};
          phase = LenLo;
        end
        LenLo: begin
          list_len[7:0] = item.data_byte;
          list_left = list_len;
          if (list_len < 16'd2) frame_err = 1'b1;
          phase = NameLen;
        end
        NameLen: begin
          if (!name_err) begin
            if (list_left == 16'd0) begin
              frame_err = 1'b1;
            end else begin
              list_left--;
              if (item.data_byte == 8'd0 || {8'd0, item.data_byte} > list_left) begin
                name_err = 1'b1;
              end else begin
                name_left = item.data_byte;
                first_byte = 1'b1;
                phase = NameBody;
              end
            end
          end
        end
        default: begin
          r.name_byte = item.data_byte;
          r.in_name = 1'b1;
          r.name_start = first_byte;
          first_byte = 1'b0;
          r.name_index = names;
          if (list_left != 16'd0) list_left--;
          if (name_left != 8'd0) name_left--;
          if (name_left == 8'd0) begin
            r.name_end = 1'b1;
            if (names != NamesMax) names++;
            phase = NameLen;
          end
        end
      endcase
      if (item.last) begin
        bad_frame = frame_err || phase == LenHi || phase == LenLo || list_len < 16'd2 ||
                    {1'b0, seen} != {2'b00, list_len} + 18'd2;
        r.done_res = 1'b1;
        r.status = bad_frame ? StatusFraming : (name_err ? StatusBadName : StatusOk);
        clear_body();
      end
      parse_results_q.push_back(r);
    endfunction

    task report(string msg);
      if (errors < 100) $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_field(string field, int unsigned got, int unsigned want);
      if (got != want) report($sformatf("%s got %0d expected %0d", field, got, want));
    endtask

    task check_result(alpn_out_t got);
      alpn_out_t want;
      if (parse_results_q.size() == 0) begin
        report("result with nothing outstanding");
        return;
      end
      want = parse_results_q.pop_front();
      check_field("name_byte", got.name_byte, want.name_byte);
      check_field("in_name", got.in_name, want.in_name);
      check_field("name_start", got.name_start, want.name_start);
      check_field("name_end", got.name_end, want.name_end);
      check_field("name_index", got.name_index, want.name_index);
      check_field("done_res", got.done_res, want.done_res);
      check_field("status", got.status, want.status);
    endtask

    function int results_owed();
      return parse_results_q.size();
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  alpn_in_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  alpn_out_t out_data_o;

  alpn_parse_tracker tracker;
  logic [7:0]        body_q[$];
  int                burst_left = 0;
  bit                steady = 1'b0;
  bit                hold_off = 1'b0;

  alpn_protocol_list_parser uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    tracker = new;
    tracker.clear_body();
    tracker.errors = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) tracker.parse_byte(in_data_i);
      if (out_valid_o && out_ready_i) tracker.check_result(out_data_o);
    end
  end

  task idle_gap(int cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  task pace();
    if (burst_left == 0) begin
      if (!steady) idle_gap($urandom_range(1, 6));
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
  endtask

  task send_byte(logic [7:0] data, logic last);
    in_data_i <= '{data_byte: data, last: last};
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task send_body();
    int i;
    steady = ($urandom_range(0, 4) == 0);
    for (i = 0; i < body_q.size(); i++) begin
      pace();
      send_byte(body_q[i], i == body_q.size() - 1);
    end
  endtask

  task make_random_body();
    int          mode;
    int          n;
    int          len;
    int          k;
    logic [15:0] total;
    body_q.delete();
    mode = $urandom_range(0, 19);
    if (mode < 2) begin
      k = $urandom_range(1, 8);
      repeat (k) body_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    body_q.push_back(8'h00);
    body_q.push_back(8'h00);
    n = $urandom_range(1, 5);
    repeat (n) begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 255) : $urandom_range(1, 8);
      body_q.push_back(8'(len));
      repeat (len) body_q.push_back(8'($urandom_range(0, 255)));
    end
    total = 16'(body_q.size() - 2);
    if (mode == 2) total = $urandom_range(0, 1) ? total + 16'd1 : total - 16'd1;
    body_q[0] = total[15:8];
    body_q[1] = total[7:0];
    case (mode)
      3: begin
        k = $urandom_range(1, body_q.size() - 1);
        repeat (k) void'(body_q.pop_back());
      end
      4: begin
        k = $urandom_range(1, 3);
        repeat (k) body_q.push_back(8'($urandom_range(0, 255)));
      end
      5: body_q[2] = 8'h00;
      6: body_q[2] = 8'hFF;
      default: ;
    endcase
  endtask

  initial begin
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_off) begin
        out_ready_i <= 1'b0;
        repeat (300) @(negedge clk_i);
        hold_off = 1'b0;
      end
      out_ready_i <= 1'b1;
      repeat (($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 12)) @(negedge clk_i);
      if ($urandom_range(0, 7) != 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk_i);
      end
    end
  end

  initial begin
    int random_bytes;
    random_bytes = 0;
    rst_ni = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    body_q = '{8'h00};
    send_body();
    body_q = '{8'h00, 8'h00};
    send_body();
    body_q = '{8'h00, 8'h01, 8'hFF};
    send_body();
    body_q = '{8'h00, 8'h03, 8'h02, 8'h68, 8'h32};
    send_body();
    body_q = '{8'h00, 8'h02, 8'h00, 8'hAA};
    send_body();
    body_q = '{8'h00, 8'h02, 8'h05, 8'h01};
    send_body();
    body_q = '{8'h00, 8'h02, 8'h01, 8'hFF, 8'h55};
    send_body();
    body_q = '{8'hFF, 8'hFF, 8'h01};
    send_body();

    hold_off = 1'b1;
    while (random_bytes < 1000) begin
      make_random_body();
      random_bytes += body_q.size();
      send_body();
    end
    in_valid_i <= 1'b0;

    while (tracker.results_owed() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("alpn_protocol_list_parser regression: pass");
    end else begin
      $display("alpn_protocol_list_parser regression: fail");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("alpn_protocol_list_parser regression: fail");
    $finish;
  end

endmodule

@@ filelist.f @@
design/alpn_pkg.sv
design/alpn_in_stage.sv
design/alpn_parse.sv
design/alpn_protocol_list_parser.sv
sim/tb.sv
